// ----- design/skh_pkg.sv -----
// Shared types, constants and exp tables for the keypoint heatmap softmax.
package skh_pkg;

  localparam int unsigned LogitW = 16;
  localparam int unsigned ProbW  = 16;
  localparam int unsigned PixW   = 10;
  localparam int unsigned CfgW   = 8;
  localparam int unsigned SumW   = 23;
  localparam int unsigned QuoW   = 17;
  localparam int unsigned ExpTabW = 17;

  localparam logic REG_CELLS_ACROSS = 1'b0;
  localparam logic REG_CELLS_DOWN   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_X_RD,
    ST_X_M1,
    ST_X_M2,
    ST_X_WR,
    ST_D_RD,
    ST_D_LD,
    ST_D_DV,
    ST_D_OUT
  } state_e;

  typedef struct packed {
    logic accept;
    logic pass_init;
    logic exp_rd;
    logic mul1;
    logic mul2;
    logic exp_wr;
    logic div_init;
    logic div_rd;
    logic div_load;
    logic div_step;
    logic emit;
    logic cell_done;
  } cmd_t;

  typedef struct packed {
    logic last_logit;
    logic exp_last;
    logic div_done;
    logic emit_last;
  } status_t;

  // round(65536*exp(-n)) for whole units of the distance to the maximum.
  function automatic logic [ExpTabW-1:0] exp_whole(input logic [7:0] n);
    logic [ExpTabW-1:0] r;
    case (n)
      8'd0:    r = 17'd65536;
      8'd1:    r = 17'd24109;
      8'd2:    r = 17'd8869;
      8'd3:    r = 17'd3263;
      8'd4:    r = 17'd1200;
      8'd5:    r = 17'd442;
      8'd6:    r = 17'd162;
      8'd7:    r = 17'd60;
      8'd8:    r = 17'd22;
      8'd9:    r = 17'd8;
      8'd10:   r = 17'd3;
      8'd11:   r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  function automatic logic [ExpTabW-1:0] exp_sixteenth(input logic [3:0] k);
    logic [ExpTabW-1:0] r;
    case (k)
      4'd0:  r = 17'd65536;
      4'd1:  r = 17'd61565;
      4'd2:  r = 17'd57835;
      4'd3:  r = 17'd54331;
      4'd4:  r = 17'd51039;
      4'd5:  r = 17'd47947;
      4'd6:  r = 17'd45042;
      4'd7:  r = 17'd42313;
      4'd8:  r = 17'd39750;
      4'd9:  r = 17'd37341;
      4'd10: r = 17'd35079;
      4'd11: r = 17'd32954;
      4'd12: r = 17'd30957;
      4'd13: r = 17'd29081;
      4'd14: r = 17'd27319;
      default: r = 17'd25664;
    endcase
    return r;
  endfunction

  function automatic logic [ExpTabW-1:0] exp_fine(input logic [3:0] k);
    logic [ExpTabW-1:0] r;
    case (k)
      4'd0:  r = 17'd65536;
      4'd1:  r = 17'd65280;
      4'd2:  r = 17'd65026;
      4'd3:  r = 17'd64772;
      4'd4:  r = 17'd64520;
      4'd5:  r = 17'd64268;
      4'd6:  r = 17'd64018;
      4'd7:  r = 17'd63768;
      4'd8:  r = 17'd63520;
      4'd9:  r = 17'd63272;
      4'd10: r = 17'd63025;
      4'd11: r = 17'd62780;
      4'd12: r = 17'd62535;
      4'd13: r = 17'd62291;
      4'd14: r = 17'd62048;
      default: r = 17'd61806;
    endcase
    return r;
  endfunction

endpackage

// ----- design/skh_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module skh_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 65
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- design/skh_ctrl.sv -----
// Sequencer that steps the collect, exp, divide and emit passes of one cell.
module skh_ctrl
  import skh_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i && status_i.last_logit) state_d = ST_X_RD;
      end
      ST_X_RD: state_d = ST_X_M1;
      ST_X_M1: state_d = ST_X_M2;
      ST_X_M2: state_d = ST_X_WR;
      ST_X_WR: state_d = status_i.exp_last ? ST_D_RD : ST_X_RD;
      ST_D_RD: state_d = ST_D_LD;
      ST_D_LD: state_d = ST_D_DV;
      ST_D_DV: begin
        if (status_i.div_done) state_d = ST_D_OUT;
      end
      ST_D_OUT: state_d = status_i.emit_last ? ST_IDLE : ST_D_RD;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o          = 1'b0;
        cmd_o.accept    = start_i;
        cmd_o.pass_init = start_i && status_i.last_logit;
      end
      ST_X_RD: cmd_o.exp_rd = 1'b1;
      ST_X_M1: cmd_o.mul1 = 1'b1;
      ST_X_M2: cmd_o.mul2 = 1'b1;
      ST_X_WR: begin
        cmd_o.exp_wr   = 1'b1;
        cmd_o.div_init = status_i.exp_last;
      end
      ST_D_RD: cmd_o.div_rd = 1'b1;
      ST_D_LD: cmd_o.div_load = 1'b1;
      ST_D_DV: cmd_o.div_step = 1'b1;
      ST_D_OUT: begin
        cmd_o.emit      = 1'b1;
        cmd_o.cell_done = status_i.emit_last;
      end
      default: busy_o = 1'b1;
    endcase
  end

endmodule

// ----- design/skh_datapath.sv -----
// Logit and exp stores, max tracker, exp unit, shared divider and cell position.
module skh_datapath
  import skh_pkg::*;
#(
  parameter int unsigned LOGIT_CHANNELS   = 65,
  parameter int unsigned GRID_SIDE        = 8,
  parameter int unsigned MAX_CELLS_ACROSS = 128,
  parameter int unsigned MAX_CELLS_DOWN   = 128
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  output status_t                  status_o,
  input  logic signed [LogitW-1:0] logit_i,
  input  logic                     cfg_we_i,
  input  logic                     cfg_index_i,
  input  logic [CfgW-1:0]          cfg_data_i,
  output logic                     valid_o,
  output logic [ProbW-1:0]         probability_o,
  output logic [PixW-1:0]          pixel_x_o,
  output logic [PixW-1:0]          pixel_y_o,
  output logic                     last_of_cell_o,
  output logic                     last_of_frame_o
);

  localparam int unsigned ChW   = $clog2(LOGIT_CHANNELS);
  localparam int unsigned Emit  = (GRID_SIDE * GRID_SIDE < LOGIT_CHANNELS) ?
                                  GRID_SIDE * GRID_SIDE : LOGIT_CHANNELS - 1;
  localparam int unsigned SubW  = $clog2(GRID_SIDE + 1);
  localparam int unsigned ColW  = $clog2(MAX_CELLS_ACROSS + 1);
  localparam int unsigned RowW  = $clog2(MAX_CELLS_DOWN + 1);
  localparam int unsigned IterW = $clog2(QuoW + 1);

  // Configuration.
  logic [CfgW-1:0] across_q, down_q, across_eff, down_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      across_q <= 8'd80;
      down_q   <= 8'd60;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_CELLS_ACROSS) across_q <= cfg_data_i;
      if (cfg_index_i == REG_CELLS_DOWN)   down_q   <= cfg_data_i;
    end
  end

  always_comb begin
    across_eff = across_q;
    if (across_q == '0) across_eff = 8'd1;
    else if (across_q > CfgW'(MAX_CELLS_ACROSS)) across_eff = CfgW'(MAX_CELLS_ACROSS);
    down_eff = down_q;
    if (down_q == '0) down_eff = 8'd1;
    else if (down_q > CfgW'(MAX_CELLS_DOWN)) down_eff = CfgW'(MAX_CELLS_DOWN);
  end

  // Collect pass: logit count and running maximum.
  logic [ChW-1:0]           count_q;
  logic signed [LogitW-1:0] max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      max_q   <= 16'sh8000;
    end else if (cmd_i.cell_done) begin
      count_q <= '0;
      max_q   <= 16'sh8000;
    end else if (cmd_i.accept) begin
      if (count_q != ChW'(LOGIT_CHANNELS - 1)) count_q <= count_q + 1'b1;
      if (logit_i > max_q) max_q <= logit_i;
    end
  end

  // Channel index shared by the exp and emit passes.
  logic [ChW-1:0] k_q;
  logic [SumW-1:0] sum_q;

  logic [LogitW-1:0] logit_rd;
  logic [ProbW-1:0]  exp_rd;
  logic [ProbW-1:0]  exp_q;

  skh_ram #(.WIDTH(LogitW), .DEPTH(LOGIT_CHANNELS)) u_logit_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept),
    .waddr_i (count_q),
    .wdata_i (logit_i),
    .raddr_i (k_q),
    .rdata_o (logit_rd)
  );

  skh_ram #(.WIDTH(ProbW), .DEPTH(LOGIT_CHANNELS)) u_exp_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.exp_wr),
    .waddr_i (k_q),
    .wdata_i (exp_q),
    .raddr_i (k_q),
    .rdata_o (exp_rd)
  );

  // Exp unit: two registered table multiplies.
  logic [LogitW-1:0]    distance;
  logic [ExpTabW-1:0]   p1_q;
  logic [3:0]           fine_q;
  logic [2*ExpTabW-1:0] prod1, prod2;

  assign distance = LogitW'(max_q - $signed(logit_rd));
  assign prod1 = exp_whole(distance[15:8]) * exp_sixteenth(distance[7:4]) + 34'd32768;
  assign prod2 = p1_q * exp_fine(fine_q) + 34'd32768;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      p1_q   <= prod1[32:16];
      fine_q <= distance[3:0];
    end
    if (cmd_i.mul2) begin
      exp_q <= (prod2[33:16] > 18'd65535) ? 16'hFFFF : prod2[31:16];
    end
  end

  // Restoring divider, one quotient bit per cycle. The sum is at least 65535,
  // so the top 16 numerator bits are below it and 17 steps cover the quotient.
  logic [32:0]     num;
  logic [SumW-1:0] rem_q;
  logic [QuoW-1:0] nbits_q, quo_q;
  logic [IterW-1:0] iter_q;
  logic [SumW:0]   trial;

  assign num   = {1'b0, exp_rd, 16'd0} + 33'(sum_q >> 1);
  assign trial = {rem_q, nbits_q[QuoW-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      rem_q   <= SumW'(num[32:17]);
      nbits_q <= num[16:0];
      quo_q   <= '0;
      iter_q  <= IterW'(QuoW);
    end else if (cmd_i.div_step) begin
      nbits_q <= {nbits_q[QuoW-2:0], 1'b0};
      iter_q  <= iter_q - 1'b1;
      if (trial >= {1'b0, sum_q}) begin
        rem_q <= SumW'(trial - {1'b0, sum_q});
        quo_q <= {quo_q[QuoW-2:0], 1'b1};
      end else begin
        rem_q <= SumW'(trial);
        quo_q <= {quo_q[QuoW-2:0], 1'b0};
      end
    end
  end

  // Channel index, sum and subpixel counters.
  logic [SubW-1:0] sx_q, sy_q;
  logic [ColW-1:0] col_q;
  logic [RowW-1:0] row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q   <= '0;
      sum_q <= '0;
      sx_q  <= '0;
      sy_q  <= '0;
    end else begin
      if (cmd_i.pass_init) begin
        k_q   <= '0;
        sum_q <= '0;
      end else if (cmd_i.div_init) begin
        k_q   <= '0;
        sum_q <= sum_q + SumW'(exp_q);
        sx_q  <= '0;
        sy_q  <= '0;
      end else if (cmd_i.exp_wr) begin
        k_q   <= k_q + 1'b1;
        sum_q <= sum_q + SumW'(exp_q);
      end else if (cmd_i.emit) begin
        k_q <= k_q + 1'b1;
        if (sx_q == SubW'(GRID_SIDE - 1)) begin
          sx_q <= '0;
          sy_q <= sy_q + 1'b1;
        end else begin
          sx_q <= sx_q + 1'b1;
        end
      end
    end
  end

  // Cell position in the grid.
  logic col_wrap, row_wrap, frame_end;

  assign col_wrap  = (9'(col_q) + 9'd1) >= 9'(across_eff);
  assign row_wrap  = (9'(row_q) + 9'd1) >= 9'(down_eff);
  assign frame_end = col_wrap && row_wrap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.cell_done) begin
      if (col_wrap) begin
        col_q <= '0;
        row_q <= row_wrap ? '0 : row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  assign status_o.last_logit = (count_q == ChW'(LOGIT_CHANNELS - 1));
  assign status_o.exp_last   = (k_q == ChW'(LOGIT_CHANNELS - 1));
  assign status_o.div_done   = (iter_q == IterW'(1));
  assign status_o.emit_last  = (k_q == ChW'(Emit - 1));

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      probability_o   <= (quo_q > 17'd65535) ? 16'hFFFF : quo_q[15:0];
      pixel_x_o       <= PixW'(PixW'(col_q) * PixW'(GRID_SIDE) + PixW'(sx_q));
      pixel_y_o       <= PixW'(PixW'(row_q) * PixW'(GRID_SIDE) + PixW'(sy_q));
      last_of_cell_o  <= status_o.emit_last;
      last_of_frame_o <= status_o.emit_last && frame_end;
    end
  end

endmodule

// ----- design/softmax_keypoint_heatmap_core.sv -----
// Top level of the keypoint heatmap softmax with 8x8 depth-to-space.
//
//  Channel   Direction  Handshake                    Payload
//  -------   ---------  ---------------------------  ------------------------------
//  logit     in         start_i high, busy_o low     logit_i (signed Q8.8)
//  result    out        valid_o strobe, one cycle    probability_o, pixel_x_o,
//                                                    pixel_y_o, last_of_cell_o,
//                                                    last_of_frame_o
//  config    in         cfg_we_i high                cfg_index_i, cfg_data_i
//
// Logits of a cell are taken one word per cycle while busy_o is low. After the
// last channel of a cell the block goes busy: the exp pass reads, multiplies
// twice and writes back each channel, then each probability is read, loaded
// into the one-bit-per-cycle restoring divider and emitted. Results cannot be
// stalled; each word is shown for one cycle. Reset returns the grid position
// to the first cell and restores the register defaults; the logit and exp
// stores are not cleared.
module softmax_keypoint_heatmap_core
  import skh_pkg::*;
#(
  parameter int unsigned LOGIT_CHANNELS   = 65,
  parameter int unsigned GRID_SIDE        = 8,
  parameter int unsigned MAX_CELLS_ACROSS = 128,
  parameter int unsigned MAX_CELLS_DOWN   = 128
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic signed [LogitW-1:0] logit_i,
  input  logic                     cfg_we_i,
  input  logic                     cfg_index_i,
  input  logic [CfgW-1:0]          cfg_data_i,
  output logic                     valid_o,
  output logic [ProbW-1:0]         probability_o,
  output logic [PixW-1:0]          pixel_x_o,
  output logic [PixW-1:0]          pixel_y_o,
  output logic                     last_of_cell_o,
  output logic                     last_of_frame_o
);

  cmd_t    cmd;
  status_t status;

  // The controller only sequences; all counters and arithmetic live in the
  // datapath, which reports the pass boundaries back as status.
  skh_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  skh_datapath #(
    .LOGIT_CHANNELS   (LOGIT_CHANNELS),
    .GRID_SIDE        (GRID_SIDE),
    .MAX_CELLS_ACROSS (MAX_CELLS_ACROSS),
    .MAX_CELLS_DOWN   (MAX_CELLS_DOWN)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .logit_i         (logit_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .valid_o         (valid_o),
    .probability_o   (probability_o),
    .pixel_x_o       (pixel_x_o),
    .pixel_y_o       (pixel_y_o),
    .last_of_cell_o  (last_of_cell_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule

// ----- design/skh_checker.sv -----
// Port-level checker for the heatmap softmax, bound to the top level.
module skh_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic busy_o,
  input logic valid_o,
  input logic last_of_cell_o,
  input logic last_of_frame_o
);

  a_valid_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy_o))
    else $error("result word without a busy cycle before it");

  a_frame_in_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_of_frame_o) |-> last_of_cell_o)
    else $error("frame end not on the last word of a cell");

  a_words_spaced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("two result words in consecutive cycles");

  a_busy_during_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_of_cell_o) |-> busy_o)
    else $error("idle in the middle of a cell's results");

endmodule

bind softmax_keypoint_heatmap_core skh_checker u_skh_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .busy_o          (busy_o),
  .valid_o         (valid_o),
  .last_of_cell_o  (last_of_cell_o),
  .last_of_frame_o (last_of_frame_o)
);

// ----- dv/softmax_keypoint_heatmap_core_tb.sv -----
// Self-checking testbench for the keypoint heatmap softmax core.
`timescale 1ns / 1ps

module softmax_keypoint_heatmap_core_tb
  import skh_pkg::*;
();

  localparam int unsigned Channels  = 65;
  localparam int unsigned Side      = 8;
  localparam int unsigned PerCell   = Side * Side;
  localparam int unsigned MaxAcross = 128;
  localparam int unsigned MaxDown   = 128;
  localparam int unsigned QuietLimit = 6000;
  localparam int unsigned SettleCycles = 40;

  // Logit patterns for one cell.
  typedef enum int {
    CELL_RANDOM,
    CELL_CLUSTER,
    CELL_FLAT
  } cell_mode_e;

  // One expected probability word together with its heatmap position.
  typedef struct packed {
    logic [ProbW-1:0] prob;
    logic [PixW-1:0]  px;
    logic [PixW-1:0]  py;
    logic             cell_end;
    logic             frame_end;
  } heat_word_t;

  // Exp tables: whole units, sixteenths and 1/256 steps of the distance.
  localparam int unsigned ExpWholeTab [12] = '{
    65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1
  };
  localparam int unsigned ExpSixteenthTab [16] = '{
    65536, 61565, 57835, 54331, 51039, 47947, 45042, 42313,
    39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664
  };
  localparam int unsigned ExpFineTab [16] = '{
    65536, 65280, 65026, 64772, 64520, 64268, 64018, 63768,
    63520, 63272, 63025, 62780, 62535, 62291, 62048, 61806
  };

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start_i;
  logic                     busy_o;
  logic signed [LogitW-1:0] logit_i;
  logic                     cfg_we_i;
  logic                     cfg_index_i;
  logic [CfgW-1:0]          cfg_data_i;
  logic                     valid_o;
  logic [ProbW-1:0]         probability_o;
  logic [PixW-1:0]          pixel_x_o;
  logic [PixW-1:0]          pixel_y_o;
  logic                     last_of_cell_o;
  logic                     last_of_frame_o;

  softmax_keypoint_heatmap_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .logit_i         (logit_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .valid_o         (valid_o),
    .probability_o   (probability_o),
    .pixel_x_o       (pixel_x_o),
    .pixel_y_o       (pixel_y_o),
    .last_of_cell_o  (last_of_cell_o),
    .last_of_frame_o (last_of_frame_o)
  );

  // Shadow state of the softmax: stored logits, running maximum, channel
  // count, grid position and the two grid size registers.
  logic signed [LogitW-1:0] cell_logits [Channels];
  logic signed [LogitW-1:0] cell_max;
  int unsigned              channel_idx;
  int unsigned              cell_col;
  int unsigned              cell_row;
  logic [CfgW-1:0]          across_reg;
  logic [CfgW-1:0]          down_reg;

  heat_word_t heat_q[$];

  int unsigned error_count;
  int unsigned logits_sent;
  int unsigned words_checked;
  int unsigned cells_done;
  int unsigned frames_done;
  int unsigned quiet_cycles;
  bit          burst_mode;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Q0.16 value of exp(-d/256), built from three table lookups.
  function automatic logic [15:0] exp_of_distance(input logic [15:0] d);
    longint unsigned e;
    if (d[15:8] >= 12) return 16'd0;
    e = ExpWholeTab[d[15:8]];
    e = (e * ExpSixteenthTab[d[7:4]] + 32768) >> 16;
    e = (e * ExpFineTab[d[3:0]] + 32768) >> 16;
    return (e > 65535) ? 16'hFFFF : e[15:0];
  endfunction

  function automatic int unsigned clamp_cells(input logic [CfgW-1:0] v, input int unsigned most);
    if (v == 0) return 1;
    return (v > most) ? most : v;
  endfunction

  // Takes one accepted logit into the shadow state. The last channel of a
  // cell produces the 64 expected probability words and advances the grid.
  task automatic absorb_logit(input logic signed [LogitW-1:0] v);
    logic [15:0]     exps [Channels];
    logic [15:0]     distance;
    int unsigned     sum;
    int unsigned     across;
    int unsigned     down;
    bit              at_frame_end;
    longint unsigned p;
    heat_word_t      w;
    cell_logits[channel_idx] = v;
    if (v > cell_max) cell_max = v;
    if (channel_idx + 1 < Channels) begin
      channel_idx++;
      return;
    end
    sum = 0;
    for (int c = 0; c < Channels; c++) begin
      distance = cell_max - cell_logits[c];
      exps[c] = exp_of_distance(distance);
      sum = (sum + exps[c]) & 32'h7F_FFFF;
    end
    across = clamp_cells(across_reg, MaxAcross);
    down = clamp_cells(down_reg, MaxDown);
    at_frame_end = (cell_col + 1 >= across) && (cell_row + 1 >= down);
    for (int c = 0; c < PerCell; c++) begin
      p = 0;
      if (sum != 0) p = ((longint'(exps[c]) << 16) + (sum >> 1)) / sum;
      if (p > 65535) p = 65535;
      w.prob = p[15:0];
      w.px = PixW'(cell_col * Side + c % Side);
      w.py = PixW'(cell_row * Side + c / Side);
      w.cell_end = (c == PerCell - 1);
      w.frame_end = (c == PerCell - 1) && at_frame_end;
      heat_q.insert(heat_q.size(), w);
    end
    cell_max = 16'sh8000;
    channel_idx = 0;
    cells_done++;
    if (at_frame_end) frames_done++;
    if (cell_col + 1 >= across) begin
      cell_col = 0;
      cell_row = (cell_row + 1 >= down) ? 0 : cell_row + 1;
    end else begin
      cell_col++;
    end
  endtask

  // Mostly short sender gaps, a few long ones, none while in burst mode.
  function automatic int unsigned pick_gap();
    if (burst_mode) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(8, 40);
  endfunction

  // Offers one logit word, holds it until the core takes it, then updates
  // the shadow state. Returns at a falling edge with start lowered.
  task automatic send_logit(input logic signed [LogitW-1:0] v);
    bit taken;
    repeat (pick_gap()) @(negedge clk_i);
    start_i = 1'b1;
    logit_i = v;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !busy_o;
    end
    absorb_logit(v);
    logits_sent++;
    @(negedge clk_i);
    start_i = 1'b0;
  endtask

  task automatic send_cell(input cell_mode_e mode);
    logic signed [LogitW-1:0] base;
    logic signed [LogitW-1:0] v;
    base = LogitW'($urandom_range(0, 16'hFFFF));
    if (base > 16'sd29000) base = 16'sd29000;
    for (int c = 0; c < Channels; c++) begin
      case (mode)
        CELL_RANDOM: begin
          v = LogitW'($urandom_range(0, 16'hFFFF));
        end
        CELL_CLUSTER: begin
          // Distances under twelve units keep every lookup within the exp tables.
          v = LogitW'(base + $signed(17'($urandom_range(0, 3071))));
        end
        default: begin
          v = base;
        end
      endcase
      send_logit(v);
    end
  endtask

  task automatic write_reg(input logic index, input logic [CfgW-1:0] value);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = index;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (index == REG_CELLS_ACROSS) across_reg = value;
    else down_reg = value;
  endtask

  // Waits until every expected word has arrived and the core has settled.
  task automatic wait_drained();
    while (heat_q.size() != 0 || busy_o) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d (word %0d)", what, got, want,
             words_checked);
    error_count++;
  endtask

  // Every strobed word is compared with the oldest expectation.
  always @(posedge clk_i) begin
    heat_word_t w;
    if (rst_ni && valid_o) begin
      if (heat_q.size() == 0) begin
        report("unexpected word", 1, 0);
      end else begin
        w = heat_q.pop_front();
        if (probability_o !== w.prob) report("probability", probability_o, w.prob);
        if (pixel_x_o !== w.px) report("pixel_x", pixel_x_o, w.px);
        if (pixel_y_o !== w.py) report("pixel_y", pixel_y_o, w.py);
        if (last_of_cell_o !== w.cell_end) report("last_of_cell", last_of_cell_o, w.cell_end);
        if (last_of_frame_o !== w.frame_end)
          report("last_of_frame", last_of_frame_o, w.frame_end);
        words_checked++;
      end
    end
  end

  // Watchdog: the run ends if neither side moves a word for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || valid_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QuietLimit) begin
        $display("watchdog: no handshake for %0d cycles", QuietLimit);
        $display("softmax_keypoint_heatmap_core_tb: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Default 80 by 60 grid: a flat cell, every probability equal.
  task automatic test_reset_defaults();
    send_cell(CELL_FLAT);
    wait_drained();
  endtask

  // Extremes of the logit, sent back to back: a lone maximum that saturates
  // at 65535 while every other channel falls beyond the exp table.
  task automatic test_logit_extremes();
    burst_mode = 1'b1;
    for (int c = 0; c < Channels; c++)
      send_logit((c == 0) ? 16'sh7FFF : 16'sh8000);
    burst_mode = 1'b0;
    wait_drained();
  endtask

  // Register extremes: zero acts as one in both registers. The cell waiting
  // in column two, past the new bound, keeps its own coordinates, ends the
  // frame and the grid wraps back to the first cell.
  task automatic test_grid_sizes();
    write_reg(REG_CELLS_ACROSS, 8'd0);
    write_reg(REG_CELLS_DOWN, 8'd0);
    send_cell(CELL_CLUSTER);
    wait_drained();
  endtask

  initial begin
    start_i = 1'b0;
    logit_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = REG_CELLS_ACROSS;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    error_count = 0;
    logits_sent = 0;
    words_checked = 0;
    cells_done = 0;
    frames_done = 0;
    quiet_cycles = 0;
    burst_mode = 1'b0;
    cell_max = 16'sh8000;
    channel_idx = 0;
    cell_col = 0;
    cell_row = 0;
    across_reg = 8'd80;
    down_reg = 8'd60;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_logit_extremes();
    test_grid_sizes();
    wait_drained();

    $display("Covered %0d logit words in %0d cells, %0d frame ends, %0d probabilities checked.",
             logits_sent, cells_done, frames_done, words_checked);
    if (error_count == 0) begin
      $display("softmax_keypoint_heatmap_core_tb: done, clean");
    end else begin
      $display("softmax_keypoint_heatmap_core_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- softmax_keypoint_heatmap_core.f -----
design/skh_pkg.sv
design/skh_ram.sv
design/skh_ctrl.sv
design/skh_datapath.sv
design/softmax_keypoint_heatmap_core.sv
design/skh_checker.sv
dv/softmax_keypoint_heatmap_core_tb.sv
